[src/bitmap_page_allocator_top_defines.svh]
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Immediate-implication and next-cycle-implication checks on clk with rst.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BPA_ASSERT_IMPL(lbl, ante, cons, msg)

`define BPA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Sequencer states, command codes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int CMD_W   = 2;
  localparam int FIRST_W = 12;
  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;
  localparam int CFG_W   = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SEEK,
    ST_MARK,
    ST_FINISH
  } state_t;

endpackage

[src/bitmap_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit allocator over a bitmap of pages (1 = used). Allocate scans for
// the first free run of page_count pages and marks it; free and reserve
// clear or set a run clipped at the end of the usable pages.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | fields
//  ---------+----------------------+-----------------------------------
//  in       | in_valid / in_stall  | command, first_page, page_count
//  out      | out_valid / out_stall| status, page_index
//  cfg      | cfg_wr_en            | cfg_wr_data (usable_words)
//
//  Allocate: accept, check, a scan that steps through each scanned word one
//  same-state stretch of pages at a time (at least one step per word), a
//  seek, a mark step per word marked, and a hand-off. Free and reserve skip
//  the scan and seek word by word through the one holding first_page. A failed
//  command goes from check to hand-off. Reset clears the map at once through
//  per-word valid bits; a full, stalled output register holds the hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top #(
  parameter int TOTAL_PAGES = 4096,
  parameter int WORD_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpa_pkg::CMD_W-1:0]     command,
  input  logic [bpa_pkg::FIRST_W-1:0]   first_page,
  input  logic [bpa_pkg::COUNT_W-1:0]   page_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [bpa_pkg::INDEX_W-1:0]   page_index,
  input  logic                          cfg_wr_en,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_wr_data
);

  import bpa_pkg::*;

  localparam int DEPTH = TOTAL_PAGES / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int PW    = $clog2(TOTAL_PAGES + 1);
  localparam int XW    = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam int OW    = $clog2(WORD_BITS + 1);

  // configuration
  logic [CFG_W-1:0] usable_words;

  // sequencer
  state_t state, state_next;

  // command context
  logic [CMD_W-1:0] cmd;
  logic [XW-1:0]    lo;
  logic [XW-1:0]    hi;
  logic [XW-1:0]    cnt;
  logic [XW-1:0]    limit;
  logic [CW-1:0]    act_w;

  // scan / mark position
  logic [CW-1:0]    word_idx;
  logic [XW-1:0]    word_base;
  logic [OW-1:0]    bit_ofs;
  logic [XW-1:0]    run;
  logic [XW-1:0]    run_start;
  logic [CW-1:0]    run_word;
  logic [XW-1:0]    run_base;

  // pending result
  logic               res_fail;
  logic [INDEX_W-1:0] res_index;

  // word store ports
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // span unit
  logic          used_bit;
  logic [OW-1:0] span;

  // combinational helpers
  logic [CW-1:0]        uw_ext;
  logic [CW-1:0]        act_words_c;
  logic [XW-1:0]        limit_c;
  logic [CW-1:0]        word_inc;
  logic [XW-1:0]        base_inc;
  logic [OW-1:0]        ofs_sum;
  logic [XW-1:0]        run_sum;
  logic [XW-1:0]        pg_here;
  logic [XW-1:0]        begin_pg;
  logic [CW-1:0]        begin_word;
  logic [XW-1:0]        begin_base;
  logic [XW-1:0]        hi_raw;
  logic [XW-1:0]        hi_clip;
  logic                 word_end;
  logic                 last_word;
  logic                 found;
  logic                 seek_hit;
  logic                 mark_last;
  logic                 is_alloc;
  logic                 set_bits;
  logic                 cmd_fail;
  logic                 load_out;
  logic [WORD_BITS-1:0] mask;

  bpa_bitmap #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpa_step #(
    .WORD_BITS (WORD_BITS),
    .OW        (OW)
  ) u_step (
    .data   (rd_data),
    .offset (bit_ofs),
    .used   (used_bit),
    .span   (span)
  );

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_words <= CFG_RESET;
    end else if (cfg_wr_en) begin
      usable_words <= cfg_wr_data;
    end
  end

  // clip the word count to the map depth, then scale to pages
  assign uw_ext      = CW'(usable_words);
  assign act_words_c = (uw_ext > CW'(DEPTH)) ? CW'(DEPTH) : uw_ext;
  assign limit_c     = XW'(act_words_c) * XW'(WORD_BITS);

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign word_inc  = word_idx + CW'(1);
  assign base_inc  = word_base + XW'(WORD_BITS);
  assign ofs_sum   = bit_ofs + span;
  assign word_end  = (ofs_sum == OW'(WORD_BITS));
  assign last_word = (word_inc == act_w);
  assign run_sum   = run + XW'(span);
  assign pg_here   = word_base + XW'(bit_ofs);

  // a free stretch either extends the current run or starts a new one
  assign begin_pg   = (run == '0) ? pg_here   : run_start;
  assign begin_word = (run == '0) ? word_idx  : run_word;
  assign begin_base = (run == '0) ? word_base : run_base;
  assign found      = !used_bit && (run_sum >= cnt);

  assign seek_hit  = (base_inc > lo);
  assign mark_last = (base_inc >= hi);

  assign hi_raw  = lo + cnt;
  assign hi_clip = (hi_raw > limit) ? limit : hi_raw;

  assign is_alloc = (cmd == CMD_ALLOC);
  assign set_bits = (cmd != CMD_FREE);

  always_comb begin
    cmd_fail = 1'b0;
    if (cnt == '0) begin
      cmd_fail = 1'b1;
    end else begin
      case (cmd)
        CMD_ALLOC:   cmd_fail = (act_w == '0);
        CMD_FREE:    cmd_fail = (lo >= limit);
        CMD_RESERVE: cmd_fail = (lo >= limit);
        default:     cmd_fail = 1'b1;
      endcase
    end
  end

  // pages of the current word that fall in [lo, hi)
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ((word_base + XW'(b)) >= lo) && ((word_base + XW'(b)) < hi);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmd_fail) begin
          state_next = ST_FINISH;
        end else if (is_alloc) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_SEEK;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_next = ST_SEEK;
        end else if (word_end && last_word) begin
          state_next = ST_FINISH;
        end
      end
      ST_SEEK: begin
        if (seek_hit) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        if (mark_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs to the word store and the result register
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = word_idx[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = word_idx[AW-1:0];
    wr_data  = set_bits ? (rd_data | mask) : (rd_data & ~mask);
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        // hold off input while reset is applied
        in_stall = rst;
      end
      ST_CHECK: begin
        // fetch word 0 for the scan
        rd_en   = is_alloc && !cmd_fail;
        rd_addr = '0;
      end
      ST_SCAN: begin
        rd_en   = !found && word_end && !last_word;
        rd_addr = word_inc[AW-1:0];
      end
      ST_SEEK: begin
        rd_en = seek_hit;
      end
      ST_MARK: begin
        // write this word, fetch the next
        wr_en   = 1'b1;
        rd_en   = !mark_last;
        rd_addr = word_inc[AW-1:0];
      end
      ST_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd   <= command;
          lo    <= XW'(first_page);
          cnt   <= XW'(page_count);
          act_w <= act_words_c;
          limit <= limit_c;
        end
      end
      ST_CHECK: begin
        word_idx  <= '0;
        word_base <= '0;
        bit_ofs   <= '0;
        run       <= '0;
        hi        <= hi_clip;
        res_fail  <= cmd_fail;
        res_index <= '0;
      end
      ST_SCAN: begin
        if (used_bit) begin
          run <= '0;
        end else if (found) begin
          // retarget the mark sweep at the run just found
          lo        <= begin_pg;
          hi        <= begin_pg + cnt;
          word_idx  <= begin_word;
          word_base <= begin_base;
          res_index <= begin_pg[INDEX_W-1:0];
        end else begin
          run <= run_sum;
          if (run == '0) begin
            run_start <= pg_here;
            run_word  <= word_idx;
            run_base  <= word_base;
          end
        end
        if (!found) begin
          if (word_end) begin
            if (last_word) begin
              res_fail <= 1'b1;
            end else begin
              word_idx  <= word_inc;
              word_base <= base_inc;
              bit_ofs   <= '0;
            end
          end else begin
            bit_ofs <= ofs_sum;
          end
        end
      end
      ST_SEEK: begin
        if (!seek_hit) begin
          word_idx  <= word_inc;
          word_base <= base_inc;
        end
      end
      ST_MARK: begin
        if (!mark_last) begin
          word_idx  <= word_inc;
          word_base <= base_inc;
        end
      end
      default: begin
        run <= run;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: hold while stalled, drop once taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= res_fail;
      page_index <= res_fail ? '0 : res_index;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BPA_ASSERT_IMPL(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one word")
  `BPA_ASSERT_IMPL(a_scan_ofs, state == ST_SCAN, bit_ofs < OW'(WORD_BITS), "scan offset past word")
  `BPA_ASSERT_IMPL(a_mark_range, state == ST_MARK, word_idx < act_w, "mark beyond usable words")
  `BPA_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state == ST_CHECK, "accept without check")

endmodule

[src/bpa_bitmap.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator word store
// One write and one registered read port; per-word valid bits make
// never-written words read as all free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_bitmap #(
  parameter int DEPTH     = 128,
  parameter int WORD_BITS = 32,
  parameter int AW        = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     word_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[wr_addr] <= 1'b1;
    end
  end

  // hold the last word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= word_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

[src/bpa_step.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator span unit
// From a bit offset in one word, report whether that page is used and how
// many pages from it onward share its state up to the end of the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_step #(
  parameter int WORD_BITS = 32,
  parameter int OW        = 6
) (
  input  logic [WORD_BITS-1:0] data,
  input  logic [OW-1:0]        offset,
  output logic                 used,
  output logic [OW-1:0]        span
);

  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] tail;
  logic [WORD_BITS-1:0] diff;

  assign rem  = data >> offset;
  assign used = rem[0];
  // bits shifted in past the word end count as a change of state
  assign tail = ~({WORD_BITS{1'b1}} >> offset);
  assign diff = (rem ^ {WORD_BITS{rem[0]}}) | tail;

  // trailing-zero count of diff
  always_comb begin
    span = OW'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (diff[i]) begin
        span = OW'(i);
      end
    end
  end

endmodule
